>>> design/suv_pkg.sv
// ----------------------------------------------------------------------------
// suv_pkg
// Shared types and constants for the strict UTF-8 text validator.
// ----------------------------------------------------------------------------
package suv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACCUM_W = 21;

    localparam logic [BYTE_W-1:0]  CTRL_LIMIT     = 8'h20;
    localparam logic [BYTE_W-1:0]  DEL_CODE       = 8'h7f;
    localparam logic [BYTE_W-1:0]  ASCII_LIMIT    = 8'h80;
    localparam logic [4:0]         TWO_LEAD_MIN   = 5'd2;
    localparam logic [2:0]         FOUR_LEAD_MAX  = 3'd4;
    localparam logic [ACCUM_W-1:0] THREE_MIN      = 21'h000800;
    localparam logic [ACCUM_W-1:0] FOUR_MIN       = 21'h010000;
    localparam logic [ACCUM_W-1:0] CODE_MAX       = 21'h10ffff;
    localparam logic [ACCUM_W-1:0] SURR_LO        = 21'h00d800;
    localparam logic [ACCUM_W-1:0] SURR_HI        = 21'h00dfff;

    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    typedef struct packed {
        logic [1:0]         cont_left;
        logic [2:0]         seq_len;
        logic [ACCUM_W-1:0] accum;
        logic               error;
    } suv_state_t;

    localparam suv_state_t STATE_CLEAR = '{cont_left: 2'd0, seq_len: SEQ_NONE,
                                           accum: '0, error: 1'b0};

endpackage

>>> design/strict_utf8_text_validator_unit.sv
// ----------------------------------------------------------------------------
// strict_utf8_text_validator_unit
// Checks a byte stream, one string at a time, for strict UTF-8 text and
// returns one verdict beat on the last byte of each string.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+----------------------
//   input   | byte_valid / byte_ready     | text_byte, is_last
//   output  | result_valid / result_ready | text_valid
//
// One byte per cycle sustained. A byte is held in the input register while
// the step logic updates the string state and, on the last byte, loads
// the result register. A stalled result blocks only a last byte; other bytes
// keep flowing. Reset clears the string state and both valid flags.
// ----------------------------------------------------------------------------
module strict_utf8_text_validator_unit
    import suv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              is_last,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              text_valid
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    suv_state_t        state_reg;
    suv_state_t        state_next;
    logic              out_valid_reg;
    logic              out_data_reg;
    logic              verdict;
    logic              out_free;
    logic              consume;

    suv_step u_step (
        .state      (state_reg),
        .text_byte  (in_byte_reg),
        .is_last    (in_last_reg),
        .state_next (state_next),
        .text_valid (verdict)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign consume    = in_valid_reg && (!in_last_reg || out_free);
    assign byte_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (consume)
            begin
                state_reg <= state_next;
            end
            if (consume && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= is_last;
        end
        if (consume && in_last_reg)
        begin
            out_data_reg <= verdict;
        end
    end

    assign result_valid = out_valid_reg;
    assign text_valid   = out_data_reg;

`ifndef SYNTH
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(consume && in_last_reg))
        else $error("result beat without a last byte");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> (state_reg == STATE_CLEAR))
        else $error("string state not cleared after last byte");

    a_seq_matches_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (!state_reg.error && (state_reg.cont_left != 2'd0)) |->
        (state_reg.seq_len > {1'b0, state_reg.cont_left}))
        else $error("open sequence length below continuations left");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !(consume && in_last_reg))
        else $error("pending result overwritten");
`endif

endmodule

>>> design/suv_step.sv
// ----------------------------------------------------------------------------
// suv_step
// Next-state and verdict logic for one byte of the string.
// ----------------------------------------------------------------------------
module suv_step
    import suv_pkg::*;
(
    input  suv_state_t        state,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              is_last,
    output suv_state_t        state_next,
    output logic              text_valid
);

    suv_state_t         upd;
    logic [ACCUM_W-1:0] cp;
    logic [1:0]         cont_dec;

    assign cp       = {state.accum[ACCUM_W-7:0], text_byte[5:0]};
    assign cont_dec = state.cont_left - 2'd1;

    always_comb
    begin
        upd = state;
        if (!state.error)
        begin
            if (state.cont_left == 2'd0)
            begin
                if ((text_byte < CTRL_LIMIT) || (text_byte == DEL_CODE))
                begin
                    upd.error = 1'b1;
                end
                else if (text_byte < ASCII_LIMIT)
                begin
                    upd = state;
                end
                else if (text_byte[7:5] == 3'b110)
                begin
                    upd.accum = {16'd0, text_byte[4:0]};
                    if (text_byte[4:0] < TWO_LEAD_MIN)
                    begin
                        upd.error = 1'b1;
                    end
                    else
                    begin
                        upd.seq_len   = SEQ_TWO;
                        upd.cont_left = 2'd1;
                    end
                end
                else if (text_byte[7:4] == 4'b1110)
                begin
                    upd.accum     = {17'd0, text_byte[3:0]};
                    upd.seq_len   = SEQ_THREE;
                    upd.cont_left = 2'd2;
                end
                else if (text_byte[7:3] == 5'b11110)
                begin
                    upd.accum = {18'd0, text_byte[2:0]};
                    if (text_byte[2:0] > FOUR_LEAD_MAX)
                    begin
                        upd.error = 1'b1;
                    end
                    else
                    begin
                        upd.seq_len   = SEQ_FOUR;
                        upd.cont_left = 2'd3;
                    end
                end
                else
                begin
                    upd.error = 1'b1;
                end
            end
            else if (text_byte[7:6] != 2'b10)
            begin
                upd.error = 1'b1;
            end
            else
            begin
                upd.accum     = cp;
                upd.cont_left = cont_dec;
                if (cont_dec == 2'd0)
                begin
                    if (((state.seq_len == SEQ_THREE) && (cp < THREE_MIN)) ||
                        ((state.seq_len == SEQ_FOUR) && (cp < FOUR_MIN)) ||
                        (cp > CODE_MAX) ||
                        ((cp >= SURR_LO) && (cp <= SURR_HI)))
                    begin
                        upd.error = 1'b1;
                    end
                    upd.seq_len = SEQ_NONE;
                    upd.accum   = '0;
                end
            end
        end
    end

    assign text_valid = !upd.error && (upd.cont_left == 2'd0);
    assign state_next = is_last ? STATE_CLEAR : upd;

endmodule
